[hdl/power_button_start_led_controller_top_macros.svh]
// Assertion macros shared by the checker.
`ifndef POWER_BUTTON_START_LED_CONTROLLER_TOP_MACROS_SVH
`define POWER_BUTTON_START_LED_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define PBSL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pbsl check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define PBSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pbsl check failed");

`endif

[hdl/pbsl_pkg.sv]
`timescale 1ns / 1ps

package pbsl_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 8;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK    = 8'd2;

    localparam logic [15:0] DEBOUNCE_RST = 16'd200;
    localparam logic [15:0] FADE_RST     = 16'd64;
    localparam logic [15:0] BLINK_RST    = 16'd500;

    // light modes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_BREATHE = 2'd1;
    localparam logic [1:0] MODE_ON      = 2'd2;
    localparam logic [1:0] MODE_BLINK   = 2'd3;

    // Q8.8 levels
    localparam logic [15:0] LOW_LEVEL  = 16'd6400;
    localparam logic [15:0] TOP_LEVEL  = 16'd25600;
    localparam logic [15:0] FULL_LEVEL = 16'hFF00;

    // floor(x/10) = (x * RECIP_10) >> RECIP_SHIFT, exact for x < 2^20
    localparam logic [19:0] RECIP_10    = 20'd838861;
    localparam int          RECIP_SHIFT = 23;

    localparam logic [16:0] FADE_SAT = 17'h10000;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] fade_rate;
        logic [15:0] blink_period_ms;
    } cfg_t;

    typedef struct packed {
        logic load;   // latch input request
        logic eval;   // press logic, fade product
        logic mul;    // 0.3x scaling product
        logic upd;    // light update, load output
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

[hdl/pbsl_cfg_regs.sv]
`timescale 1ns / 1ps

module pbsl_cfg_regs
    import pbsl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_next.debounce_ms     = cfg_data;
                REG_FADE:     cfg_next.fade_rate       = cfg_data;
                REG_BLINK:    cfg_next.blink_period_ms = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.fade_rate       <= FADE_RST;
            cfg_reg.blink_period_ms <= BLINK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/pbsl_ctrl.sv]
`timescale 1ns / 1ps

module pbsl_ctrl
    import pbsl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.upd    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/pbsl_datapath.sv]
`timescale 1ns / 1ps

module pbsl_datapath
    import pbsl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cfg_t                  cfg,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    // latched request
    logic [31:0] now_reg;
    logic        btn_reg, veh_reg, mcu_reg, bms_reg, obc_reg;

    // block state
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] bright_reg, bright_next;
    logic        rising_reg, rising_next;
    logic [31:0] llt_reg, llt_next;
    logic [31:0] lpt_reg, lpt_next;
    logic        crank_reg, crank_next;
    logic        mcu_ok_reg, mcu_ok_next;
    logic        bms_ok_reg, bms_ok_next;
    logic        obc_act_reg, obc_act_next;
    logic [7:0]  duty_reg, duty_next;

    // per-request working values
    logic [31:0] el_reg;
    logic [47:0] raw_reg;
    logic [16:0] q_reg;
    logic        start_reg, fault_reg, stop_reg, keyon_reg;

    // output stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [31:0] dt_press;
    logic        gate, keyon, press, start, fault, stop;
    logic [1:0]  mode_p;
    logic        mcu_ok_p, bms_ok_p, obc_act_p;
    logic [31:0] el;
    logic [47:0] raw;
    logic [19:0] x3;
    logic [39:0] scaled;
    logic [16:0] fade;
    logic [17:0] sum;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // ---------------- press and readiness logic ----------------
    always_comb begin
        dt_press  = now_reg - lpt_reg;
        gate      = dt_press > {16'd0, cfg.debounce_ms};
        keyon     = crank_reg && gate;
        press     = btn_reg && gate;
        start     = press && !veh_reg && mcu_reg && bms_reg && !obc_reg;
        fault     = press && !veh_reg && !start;
        stop      = press && veh_reg;
        el        = now_reg - llt_reg;
        raw       = el * {16'd0, cfg.fade_rate};

        mode_p    = mode_reg;
        mcu_ok_p  = mcu_ok_reg;
        bms_ok_p  = bms_ok_reg;
        obc_act_p = obc_act_reg;
        bright_next = bright_reg;
        rising_next = rising_reg;
        duty_next   = duty_reg;
        lpt_next    = lpt_reg;
        crank_next  = keyon ? 1'b0 : crank_reg;

        if (press) begin
            lpt_next  = now_reg;
            duty_next = 8'd0;    // light forced off on a press
            mcu_ok_p  = mcu_reg;
            bms_ok_p  = bms_reg;
            obc_act_p = obc_reg;
            if (stop) begin
                bright_next = 16'd0;
                rising_next = 1'b0;
            end
            if (start) begin
                mode_p     = MODE_ON;
                crank_next = 1'b1;
            end else if (obc_reg) begin
                mode_p = MODE_OFF;
            end else if (!mcu_reg || !bms_reg) begin
                mode_p = MODE_BLINK;
            end else begin
                mode_p = MODE_BREATHE;
            end
        end

        // re-checks of devices not yet ready / charger active
        mode_next    = mode_p;
        mcu_ok_next  = mcu_ok_p || mcu_reg;
        bms_ok_next  = bms_ok_p || bms_reg;
        obc_act_next = obc_act_p && obc_reg;
        if ((!mcu_ok_p && !mcu_reg) || (!bms_ok_p && !bms_reg)) begin
            mode_next = MODE_BLINK;
        end
        if (obc_act_p && obc_reg) begin
            mode_next = MODE_OFF;
        end
    end

    // 0.3x scaling: (3x)/10 by reciprocal
    assign x3     = {raw_reg[17:0], 1'b0} + {2'd0, raw_reg[17:0]};
    assign scaled = x3 * RECIP_10;

    // ---------------- light update ----------------
    logic [15:0] b_upd;
    logic        r_upd;
    logic [31:0] llt_upd;
    logic [7:0]  d_upd;

    always_comb begin
        if (bright_reg < LOW_LEVEL) begin
            if ((|raw_reg[47:18]) || q_reg[16]) begin
                fade = FADE_SAT;
            end else begin
                fade = q_reg;
            end
        end else begin
            if (|raw_reg[47:16]) begin
                fade = FADE_SAT;
            end else begin
                fade = {1'b0, raw_reg[15:0]};
            end
        end
        sum = {2'd0, bright_reg} + {1'b0, fade};

        b_upd   = bright_reg;
        r_upd   = rising_reg;
        llt_upd = llt_reg;
        d_upd   = duty_reg;
        case (mode_reg)
            MODE_OFF: d_upd = 8'd0;
            MODE_BREATHE: begin
                if (rising_reg) begin
                    if (sum < {2'd0, TOP_LEVEL}) begin
                        b_upd = sum[15:0];
                    end else begin
                        b_upd = TOP_LEVEL;
                        r_upd = 1'b0;
                    end
                end else begin
                    if ({1'b0, bright_reg} > fade) begin
                        b_upd = bright_reg - fade[15:0];
                        r_upd = (fade == 17'd0);
                    end else begin
                        b_upd = 16'd0;
                        r_upd = 1'b1;
                    end
                end
                llt_upd = now_reg;
                d_upd   = b_upd[15:8];
            end
            MODE_ON: d_upd = 8'hFF;
            default: begin
                if (el_reg >= {16'd0, cfg.blink_period_ms}) begin
                    llt_upd = now_reg;
                    b_upd   = (bright_reg <= TOP_LEVEL) ? FULL_LEVEL : 16'd0;
                    d_upd   = b_upd[15:8];
                end
            end
        endcase
        llt_next = llt_upd;
    end

    // request and working registers (payload, no reset)
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg <= in_data[31:0];
            btn_reg <= in_data[32];
            veh_reg <= in_data[33];
            mcu_reg <= in_data[34];
            bms_reg <= in_data[35];
            obc_reg <= in_data[36];
        end
        if (cmd.eval) begin
            el_reg    <= el;
            raw_reg   <= raw;
            start_reg <= start;
            fault_reg <= fault;
            stop_reg  <= stop;
            keyon_reg <= keyon;
        end
        if (cmd.mul) begin
            q_reg <= scaled[RECIP_SHIFT+16:RECIP_SHIFT];
        end
        if (cmd.upd) begin
            out_data_reg <= {4'd0, keyon_reg, stop_reg, fault_reg, start_reg, d_upd};
        end
    end

    // block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_BREATHE;
            bright_reg    <= 16'd0;
            rising_reg    <= 1'b0;
            llt_reg       <= 32'd0;
            lpt_reg       <= 32'd0;
            crank_reg     <= 1'b0;
            mcu_ok_reg    <= 1'b0;
            bms_ok_reg    <= 1'b0;
            obc_act_reg   <= 1'b0;
            duty_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.eval) begin
                mode_reg    <= mode_next;
                bright_reg  <= bright_next;
                rising_reg  <= rising_next;
                lpt_reg     <= lpt_next;
                crank_reg   <= crank_next;
                mcu_ok_reg  <= mcu_ok_next;
                bms_ok_reg  <= bms_ok_next;
                obc_act_reg <= obc_act_next;
                duty_reg    <= duty_next;
            end
            if (cmd.upd) begin
                bright_reg <= b_upd;
                rising_reg <= r_upd;
                llt_reg    <= llt_next;
                duty_reg   <= d_upd;
            end
            if (cmd.upd) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[hdl/power_button_start_led_controller_top.sv]
`timescale 1ns / 1ps
// Power button start controller with status light.
// s_ channel: one update request per control-loop tick. s_tdata from bit 0:
//   now_ms[31:0], button_pressed, vehicle_on, mcu_ready, bms_ready,
//   obc_charging, zero pad to 40 bits.
// m_ channel: one result per request. m_tdata from bit 0: led_duty[7:0],
//   start_cmd, start_fault, stop_cmd, key_on_cmd, zero pad to 16 bits.
// cfg channel: cfg_index 0 debounce_ms, 1 fade_rate, 2 blink_period_ms;
//   other indexes are dropped. cfg_ready is always high.
// One request is worked at a time: accept, evaluate (fade product),
//   scale (0.3x product), update; a new request is accepted only once
//   the update step is done, as set by the four-state controller and
//   its two registered multiplies.
// Stall: the output register holds a result while m_tready is low; the next
//   request is still accepted and worked, and waits in the update step until
//   the output register frees up.
// Reset: aresetn low clears the config to 200/64/500, the light to breathing
//   at zero brightness falling, all timers and flags, and drops m_tvalid.
module power_button_start_led_controller_top
    import pbsl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // request input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms[31:0], button_pressed, vehicle_on, mcu_ready, bms_ready, obc_charging
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // led_duty[7:0], start_cmd, start_fault, stop_cmd, key_on_cmd
    output logic [OUT_DATA_W-1:0] m_tdata,
    // config writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]           cfg_data
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // config register file
    pbsl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: accept, evaluate, scale, update
    pbsl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // press logic, fade arithmetic, light state, output register
    pbsl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

[hdl/pbsl_checker.sv]
`timescale 1ns / 1ps
`include "power_button_start_led_controller_top_macros.svh"

module pbsl_checker
    import pbsl_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // stalled result holds
    `PBSL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // start, fault and stop never come together
    `PBSL_ASSERT_IMPL(a_cmd_excl, m_tvalid, $onehot0(m_tdata[10:8]))

    // a start drives the light full on
    `PBSL_ASSERT_IMPL(a_start_led, m_tvalid && m_tdata[8], m_tdata[7:0] == 8'hFF)

    // one request at a time
    `PBSL_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready)

endmodule

bind power_button_start_led_controller_top pbsl_checker u_pbsl_checker (.*);

[bench/tb.sv]
`timescale 1ns / 1ps
// Bench for the power button start controller.
// Update requests go in on the s_ channel; every request gives one result on
// the m_ channel. Expected results come from a local model of the press,
// readiness and light logic, kept in step with the register writes, and
// every result is checked field by field against the oldest expectation.
module tb;
    import pbsl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no request moving at all
    localparam int DRAIN_CYCLES = 12;    // longer than the result latency, allow some slack
    localparam int MAX_REPORTS  = 10;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;  // dropped by the block

    // one update request, last field in the low bits
    typedef struct packed {
        logic        obc_charging;
        logic        bms_ready;
        logic        mcu_ready;
        logic        vehicle_on;
        logic        button_pressed;
        logic [31:0] now_ms;
    } update_t;

    // one result, last field in the low bits
    typedef struct packed {
        logic       key_on_cmd;
        logic       stop_cmd;
        logic       start_fault;
        logic       start_cmd;
        logic [7:0] led_duty;
    } result_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input known from time zero
    // ------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [15:0]           cfg_data  = '0;

    power_button_start_led_controller_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller model: registers and state, at reset values
    // ------------------------------------------------------------------
    logic [15:0] debounce_q  = DEBOUNCE_RST;
    logic [15:0] fade_rate_q = FADE_RST;
    logic [15:0] blink_q     = BLINK_RST;

    logic [1:0]  light_mode    = MODE_BREATHE;
    logic [15:0] level         = '0;   // Q8.8 brightness
    logic        fading_up     = 1'b0;
    logic [31:0] last_light_ms = '0;
    logic [31:0] last_press_ms = '0;
    logic        crank_wait    = 1'b0;
    logic        mcu_seen_ok   = 1'b0;
    logic        bms_seen_ok   = 1'b0;
    logic        charger_busy  = 1'b0;
    logic [7:0]  duty_q        = '0;

    function automatic void set_light_mode(logic [1:0] m);
        light_mode = m;
        if (m == MODE_BREATHE) begin
            level     = '0;
            fading_up = 1'b0;
        end
    endfunction

    function automatic void check_mcu(logic r);
        mcu_seen_ok = r;
        if (!r) set_light_mode(MODE_BLINK);
    endfunction

    function automatic void check_bms(logic r);
        bms_seen_ok = r;
        if (!r) set_light_mode(MODE_BLINK);
    endfunction

    function automatic void check_charger(logic r);
        charger_busy = r;
        if (r) set_light_mode(MODE_OFF);
    endfunction

    function automatic void advance_light(logic [31:0] now);
        logic [31:0] elapsed;
        logic [63:0] el_wide;
        logic [63:0] rate_wide;
        logic [63:0] fade;
        logic [63:0] lvl;
        logic [63:0] sum;
        elapsed   = now - last_light_ms;
        el_wide   = {32'd0, elapsed};
        rate_wide = {48'd0, fade_rate_q};
        case (light_mode)
            MODE_OFF: begin
                duty_q = '0;
            end
            MODE_BREATHE: begin
                fade = el_wide * rate_wide;
                // slow fade in the dim range
                if (level < LOW_LEVEL) fade = fade * 64'd3 / 64'd10;
                lvl = {48'd0, level};
                if (fading_up) begin
                    sum = lvl + fade;
                    if (sum < {48'd0, TOP_LEVEL}) begin
                        level = sum[15:0];
                    end else begin
                        level     = TOP_LEVEL;
                        fading_up = 1'b0;
                    end
                end else begin
                    if (lvl > fade) begin
                        sum       = lvl - fade;
                        level     = sum[15:0];
                        fading_up = (fade == 64'd0);  // a zero step turns it around
                    end else begin
                        level     = '0;
                        fading_up = 1'b1;
                    end
                end
                last_light_ms = now;
                duty_q        = level[15:8];
            end
            MODE_ON: begin
                duty_q = 8'hFF;
            end
            default: begin
                if (elapsed >= {16'd0, blink_q}) begin
                    last_light_ms = now;
                    level         = (level <= TOP_LEVEL) ? FULL_LEVEL : 16'd0;
                    duty_q        = level[15:8];
                end
            end
        endcase
    endfunction

    function automatic result_t predict_update(update_t u);
        result_t r;
        r = '0;
        if (crank_wait && (u.now_ms - last_press_ms) > {16'd0, debounce_q}) begin
            r.key_on_cmd = 1'b1;
            crank_wait   = 1'b0;
        end
        if (u.button_pressed && (u.now_ms - last_press_ms) > {16'd0, debounce_q}) begin
            last_press_ms = u.now_ms;
            set_light_mode(MODE_OFF);
            advance_light(u.now_ms);
            if (!u.vehicle_on) begin
                check_mcu(u.mcu_ready);
                check_bms(u.bms_ready);
                check_charger(u.obc_charging);
                if (mcu_seen_ok && bms_seen_ok && !charger_busy) begin
                    r.start_cmd = 1'b1;
                    crank_wait  = 1'b1;
                    set_light_mode(MODE_ON);
                end else begin
                    r.start_fault = 1'b1;
                end
            end else begin
                r.stop_cmd = 1'b1;
                set_light_mode(MODE_BREATHE);
                check_mcu(u.mcu_ready);
                check_bms(u.bms_ready);
                check_charger(u.obc_charging);
            end
        end
        if (!mcu_seen_ok) check_mcu(u.mcu_ready);
        if (!bms_seen_ok) check_bms(u.bms_ready);
        if (charger_busy) check_charger(u.obc_charging);
        advance_light(u.now_ms);
        r.led_duty = duty_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Queues and counters
    // ------------------------------------------------------------------
    update_t pending_updates[$];    // filled by the stimulus, drained by the driver
    result_t expected_results[$];   // predictions waiting for their result

    int updates_sent = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int cfg_writes   = 0;
    int n_start = 0, n_stop = 0, n_fault = 0, n_key_on = 0;

    // ------------------------------------------------------------------
    // Driver: bursts of requests separated by random gaps
    // ------------------------------------------------------------------
    update_t on_bus;
    int      burst_left = 1;
    int      gap_left   = 0;

    always @(posedge aclk) begin : driver
        result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // request taken at this edge: predict its result
            if (s_tvalid && s_tready) begin
                r = predict_update(on_bus);
                expected_results.push_back(r);
                updates_sent++;
                n_start  += int'(r.start_cmd);
                n_stop   += int'(r.stop_cmd);
                n_fault  += int'(r.start_fault);
                n_key_on += int'(r.key_on_cmd);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_updates.size() != 0) begin
                    on_bus = pending_updates.pop_front();
                    s_tdata  <= {{(IN_DATA_W - $bits(update_t)){1'b0}}, on_bus};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        // a quarter of bursts run back to back, a few gaps are long
                        case ($urandom_range(0, 7))
                            0, 1:    gap_left = 0;
                            7:       gap_left = $urandom_range(13, 30);
                            default: gap_left = $urandom_range(1, 12);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks results, drives m_tready on a stall pattern of its own
    // ------------------------------------------------------------------
    int   style       = 0;   // 0 always ready, 1 coin flip, 2 long on/off stretches
    int   style_left  = 0;
    int   hold_left   = 0;
    logic ready_level = 1'b1;

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"unexpected result at %0t: duty %0d start %b fault %b",
                                  " stop %b key_on %b"},
                                 $realtime, got.led_duty, got.start_cmd, got.start_fault,
                                 got.stop_cmd, got.key_on_cmd);
                end else begin
                    want = expected_results.pop_front();
                    if (got.led_duty != want.led_duty || got.start_cmd != want.start_cmd ||
                        got.start_fault != want.start_fault || got.stop_cmd != want.stop_cmd ||
                        got.key_on_cmd != want.key_on_cmd) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"result %0d mismatch: duty %0d/%0d start %b/%b",
                                      " fault %b/%b stop %b/%b key_on %b/%b",
                                      " (expected/actual)"},
                                     results_seen, want.led_duty, got.led_duty,
                                     want.start_cmd, got.start_cmd, want.start_fault,
                                     got.start_fault, want.stop_cmd, got.stop_cmd,
                                     want.key_on_cmd, got.key_on_cmd);
                    end
                end
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 2);
                style_left = $urandom_range(50, 300);
            end else begin
                style_left--;
            end
            case (style)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if (hold_left == 0) begin
                        hold_left   = $urandom_range(1, 40);
                        ready_level = ~ready_level;
                    end else begin
                        hold_left--;
                    end
                    m_tready <= ready_level;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_results.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [31:0] stamp          = '0;   // running millisecond clock
    int          gen_debounce   = int'(DEBOUNCE_RST);
    int          session_left   = 0;
    logic        session_car    = 1'b0;
    logic        session_healthy = 1'b1;

    function automatic update_t mk(logic [31:0] now, logic btn, logic veh,
                                   logic mcu, logic bms, logic obc);
        update_t u;
        u.now_ms         = now;
        u.button_pressed = btn;
        u.vehicle_on     = veh;
        u.mcu_ready      = mcu;
        u.bms_ready      = bms;
        u.obc_charging   = obc;
        return u;
    endfunction

    // Mostly plausible drive sessions: time moving forward, presses now and
    // then, devices mostly ready. One in ten is pure noise.
    function automatic update_t next_update();
        update_t     u;
        logic [31:0] step;
        if (session_left == 0) begin
            session_left    = $urandom_range(6, 30);
            session_car     = 1'($urandom_range(0, 1));
            session_healthy = ($urandom_range(0, 4) != 0);
        end
        session_left--;
        if ($urandom_range(0, 9) == 0) begin
            u = mk($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
            stamp = u.now_ms;
        end else begin
            case ($urandom_range(0, 9))
                0:             step = 0;
                1, 2, 3, 4:    step = $urandom_range(1, 40);
                5, 6, 7:       step = $urandom_range(1, gen_debounce + 60);
                8:             step = gen_debounce + $urandom_range(1, 200);
                default:       step = $urandom_range(0, 5000);
            endcase
            stamp = stamp + step;
            if ($urandom_range(0, 7) == 0) session_car = ~session_car;
            if (session_healthy)
                u = mk(stamp, $urandom_range(0, 3) == 0, session_car,
                       $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
                       $urandom_range(0, 19) == 0);
            else
                u = mk(stamp, $urandom_range(0, 3) == 0, session_car,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end
        return u;
    endfunction

    task automatic queue_random(int count);
        repeat (count) pending_updates.push_back(next_update());
    endtask

    // returns just after an edge with nothing left in flight
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_updates.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // call just after an edge; leaves cfg_valid high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk);
        while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE: begin
                debounce_q   = val;
                gen_debounce = int'(val);
            end
            REG_FADE:  fade_rate_q = val;
            REG_BLINK: blink_q     = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_settings(logic [15:0] deb, logic [15:0] rate, logic [15:0] blink);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_FADE, rate);
        write_reg(REG_BLINK, blink);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings (debounce 200, fade 64, blink 500)
        pending_updates.push_back(mk(32'd0,    0, 0, 1, 1, 0));  // zero step, falling at 0
        pending_updates.push_back(mk(32'd100,  0, 0, 1, 1, 0));  // dim, slowed fade up
        pending_updates.push_back(mk(32'd2100, 0, 0, 1, 1, 0));  // saturates at 100
        pending_updates.push_back(mk(32'd2100, 0, 0, 1, 1, 0));  // zero step while falling
        pending_updates.push_back(mk(32'd2150, 0, 0, 1, 1, 0));
        pending_updates.push_back(mk(32'd2400, 1, 0, 1, 1, 0));  // start
        pending_updates.push_back(mk(32'd2500, 1, 0, 1, 1, 0));  // inside debounce
        pending_updates.push_back(mk(32'd2601, 0, 1, 1, 1, 0));  // key on
        pending_updates.push_back(mk(32'd2900, 1, 1, 1, 1, 0));  // stop
        pending_updates.push_back(mk(32'd3000, 1, 1, 1, 1, 0));  // bounce ignored
        pending_updates.push_back(mk(32'd3200, 1, 0, 0, 1, 0));  // motor ctrl not ready
        pending_updates.push_back(mk(32'd3700, 0, 0, 0, 1, 0));  // blinking
        pending_updates.push_back(mk(32'd4300, 0, 0, 1, 1, 0));  // recovers, blink toggles
        pending_updates.push_back(mk(32'd4600, 1, 0, 1, 0, 0));  // battery not ready
        pending_updates.push_back(mk(32'd5000, 1, 0, 1, 1, 1));  // charger busy
        pending_updates.push_back(mk(32'd5100, 0, 0, 1, 1, 0));  // charger drops
        pending_updates.push_back(mk(32'd5300, 1, 0, 1, 1, 0));  // start
        pending_updates.push_back(mk(32'hFFFF_FFF0, 0, 1, 1, 1, 0));  // key on, big gap
        pending_updates.push_back(mk(32'hFFFF_FFFF, 1, 1, 1, 1, 0));  // stop at top of range
        pending_updates.push_back(mk(32'd5,    1, 0, 1, 1, 0));  // wrapped, still bouncing
        pending_updates.push_back(mk(32'd300,  1, 0, 1, 1, 0));  // start across the wrap
        pending_updates.push_back(mk(32'd300,  0, 0, 1, 1, 1));  // same stamp, charger on
        pending_updates.push_back(mk(32'hAAAA_AAAA, 1, 0, 0, 0, 1));  // everything wrong
        pending_updates.push_back(mk(32'h5555_5555, 1, 1, 1, 1, 1));
        stamp = 32'h5555_5555;
        queue_random(100);
        wait_drained();

        // lowest settings: no debounce, no fade, blink every update
        write_reg(REG_UNUSED, 16'hFFFF);
        apply_settings(16'd0, 16'd0, 16'd0);
        queue_random(120);
        wait_drained();

        // highest settings
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(120);
        wait_drained();

        apply_settings(16'd50, 16'd256, 16'd100);
        queue_random(120);
        wait_drained();

        apply_settings(16'd200, 16'd1000, 16'd20);
        queue_random(120);
        wait_drained();

        $display("%0d updates, %0d results, %0d register writes over 5 settings",
                 updates_sent, results_seen, cfg_writes);
        $display("predicted starts %0d, stops %0d, start faults %0d, key-on %0d; %0d mismatches",
                 n_start, n_stop, n_fault, n_key_on, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
